// ----- sv/sf7_pkg.sv -----
// Shared types, constants and the weighted tap sum for the separable 7-tap filter.
// No dependencies; every other file of the block imports this package.
package sf7_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;
  localparam int TAPS       = 7;
  localparam int LINES      = TAPS - 1;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = $clog2(LINES);
  localparam int LW_W       = 10;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = 10'd480;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd270;

  localparam logic [PIX_W-1:0] WEIGHT [TAPS] = '{8'd2, 8'd15, 8'd62, 8'd98, 8'd62, 8'd15, 8'd2};

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;
  typedef logic [LINES-1:0][PIX_W-1:0] lines_t;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_start;
  } in_item_t;

  typedef struct packed {
    pixel_t filtered_pixel;
    logic   frame_last;
  } out_item_t;

  typedef struct packed {
    taps_t             taps;
    logic              access;
    logic              produce;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  x;
  } front_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  addr;
    pixel_t            data;
  } line_wr_t;

  function automatic logic [SUM_W-1:0] weighted_sum(input taps_t t);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + SUM_W'(WEIGHT[k]) * SUM_W'(t[k]);
    end
    return acc;
  endfunction

endpackage

// ----- sv/sf7_front.sv -----
// Position counters, row window and window-validity decode for incoming pixels.
// Depends on sf7_pkg.
module sf7_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  sf7_pkg::in_item_t       in_item,
  input  logic [sf7_pkg::LW_W-1:0] line_width,
  input  logic [sf7_pkg::FH_W-1:0] frame_height,
  output sf7_pkg::front_t         front
);
  import sf7_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt, cur_col;
  logic [ROW_W-1:0]  row_r, row_nxt, cur_row;
  logic [SLOT_W-1:0] slot_r, slot_nxt, cur_slot;
  pixel_t            win_r [LINES];
  logic [LW_W-1:0]   w;
  logic [FH_W-1:0]   h;
  logic [LW_W-1:0]   col_inc;
  logic [FH_W-1:0]   row_inc;

  always_comb begin
    if (line_width < LW_W'(TAPS)) begin
      w = LW_W'(TAPS);
    end else if (line_width > LW_W'(MAX_WIDTH)) begin
      w = LW_W'(MAX_WIDTH);
    end else begin
      w = line_width;
    end
    if (frame_height < FH_W'(TAPS)) begin
      h = FH_W'(TAPS);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h = FH_W'(MAX_HEIGHT);
    end else begin
      h = frame_height;
    end
  end

  always_comb begin
    cur_col = (in_item.frame_start || LW_W'(col_r) >= w) ? '0 : col_r;
    if (in_item.frame_start || FH_W'(row_r) >= h) begin
      cur_row  = '0;
      cur_slot = '0;
    end else begin
      cur_row  = row_r;
      cur_slot = slot_r;
    end

    col_inc  = LW_W'(cur_col) + LW_W'(1);
    row_inc  = FH_W'(cur_row) + FH_W'(1);
    col_nxt  = col_inc[COL_W-1:0];
    row_nxt  = cur_row;
    slot_nxt = cur_slot;
    if (col_inc >= w) begin
      col_nxt = '0;
      if (row_inc >= h) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_inc[ROW_W-1:0];
        slot_nxt = (cur_slot == SLOT_W'(LINES - 1)) ? '0 : cur_slot + SLOT_W'(1);
      end
    end

    for (int k = 0; k < LINES; k++) begin
      front.taps[k] = win_r[k];
    end
    front.taps[TAPS-1] = in_item.pixel;
    front.access  = cur_col >= COL_W'(LINES);
    front.produce = front.access && (cur_row >= ROW_W'(LINES));
    front.last    = (FH_W'(cur_row) == h - FH_W'(1)) && (LW_W'(cur_col) == w - LW_W'(1));
    front.slot    = cur_slot;
    front.x       = cur_col - COL_W'(LINES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      for (int k = 0; k < LINES; k++) begin
        win_r[k] <= '0;
      end
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      for (int k = 0; k < LINES - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[LINES-1] <= in_item.pixel;
    end
  end

endmodule

// ----- sv/sf7_line_buf.sv -----
// Six line stores of horizontal results, one memory per line, read together at one column.
// Depends on sf7_pkg.
module sf7_line_buf (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [sf7_pkg::COL_W-1:0] rd_addr,
  output sf7_pkg::lines_t           rd_data,
  input  sf7_pkg::line_wr_t         wr
);
  import sf7_pkg::*;

  for (genvar g = 0; g < LINES; g++) begin : g_line
    pixel_t mem [MAX_WIDTH];
    pixel_t rd_r;

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_r <= mem[rd_addr];
      end
      if (wr.en && wr.slot == SLOT_W'(g)) begin
        mem[wr.addr] <= wr.data;
      end
    end

    assign rd_data[g] = rd_r;
  end

endmodule

// ----- sv/sf7_filter_pipe.sv -----
// Horizontal and vertical tap sums in two registered stages, plus the output register.
// Depends on sf7_pkg; line data comes from sf7_line_buf.
module sf7_filter_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sf7_pkg::front_t     front,
  input  sf7_pkg::lines_t     rd_data,
  output sf7_pkg::line_wr_t   wr,
  output logic                out_valid,
  input  logic                out_ready,
  output sf7_pkg::out_item_t  out_item
);
  import sf7_pkg::*;

  logic      s1_v_r, s2_v_r, out_v_r;
  front_t    s1_r;
  taps_t     s2_taps_r, s2_taps_nxt;
  logic      s2_produce_r, s2_last_r;
  out_item_t out_item_r;
  logic      out_en, s2_en, s1_en, accept;
  logic [SUM_W-1:0] hsum, vsum;
  logic [SLOT_W:0]  idx;

  assign out_en   = !out_v_r || out_ready;
  assign s2_en    = !s2_v_r || !s2_produce_r || out_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;
  assign accept   = in_valid && s1_en;

  always_comb begin
    hsum = weighted_sum(s1_r.taps);
    for (int k = 0; k < LINES; k++) begin
      idx = (SLOT_W + 1)'(s1_r.slot) + (SLOT_W + 1)'(k);
      if (idx >= (SLOT_W + 1)'(LINES)) begin
        idx = idx - (SLOT_W + 1)'(LINES);
      end
      s2_taps_nxt[k] = rd_data[idx[SLOT_W-1:0]];
    end
    s2_taps_nxt[TAPS-1] = hsum[SUM_W-1 -: PIX_W];
  end

  assign wr.en   = s1_v_r && s2_en && s1_r.access;
  assign wr.slot = s1_r.slot;
  assign wr.addr = s1_r.x;
  assign wr.data = hsum[SUM_W-1 -: PIX_W];

  assign vsum = weighted_sum(s2_taps_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= accept;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (out_en) begin
        out_v_r <= s2_v_r && s2_produce_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= front;
    end
    if (s2_en) begin
      s2_taps_r    <= s2_taps_nxt;
      s2_produce_r <= s1_r.produce;
      s2_last_r    <= s1_r.last;
    end
    if (out_en) begin
      out_item_r.filtered_pixel <= vsum[SUM_W-1 -: PIX_W];
      out_item_r.frame_last     <= s2_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

// ----- sv/separable_7tap_image_filter_core.sv -----
// Top level of the separable 7-tap weighted blur: configuration registers and block wiring.
// Depends on sf7_pkg, sf7_front, sf7_line_buf and sf7_filter_pipe.
//
// Pixels enter in raster order on in_ (valid/ready), one item per clock unless stalled.
// Each item carries a pixel and a frame_start flag that restarts the row and column
// position. A filtered pixel leaves on the out_ channel only for input pixels whose
// 7x7 window lies fully inside the frame; frame_last marks the final one of a frame.
// The cfg_ channel writes line_width (index 0) and frame_height (index 1); it is
// always ready and should be used only while the block is idle.
// Throughput is one item per cycle while the output is not stalled. The accepting edge
// loads the first stage and reads the line stores; the second stage then registers the
// horizontal sum and the output register the vertical sum. When the receiver stalls, the
// output register holds its item and items that give no result still pass through;
// in_ready drops once the second stage also holds a result and the first stage holds an
// item.
// Reset clears the position counters, the row window and all stage valid bits and
// restores line_width to 480 and frame_height to 270; line stores are not cleared.
module separable_7tap_image_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sf7_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sf7_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sf7_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sf7_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sf7_pkg::*;

  logic [LW_W-1:0] line_width_r;
  logic [FH_W-1:0] frame_height_r;
  front_t          front;
  lines_t          rd_data;
  line_wr_t        wr;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_WIDTH:   line_width_r   <= cfg_data[LW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  sf7_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_item      (in_item),
    .line_width   (line_width_r),
    .frame_height (frame_height_r),
    .front        (front)
  );

  sf7_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept && front.access),
    .rd_addr (front.x),
    .rd_data (rd_data),
    .wr      (wr)
  );

  sf7_filter_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .front     (front),
    .rd_data   (rd_data),
    .wr        (wr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- sv/sf7_checker.sv -----
// Port-level checks for the separable 7-tap filter, bound to the top level.
// Depends on sf7_pkg and separable_7tap_image_filter_core.
module sf7_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sf7_pkg::out_item_t out_item,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  import sf7_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed or vanished.");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("Input stalled while the output side was free.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Pipeline not empty after reset.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("Configuration write was not taken at once.");

endmodule

bind separable_7tap_image_filter_core sf7_checker u_sf7_checker (.*);

// ----- test/separable_7tap_image_filter_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the separable 7-tap blur core. It predicts every filtered pixel from the
// accepted pixel and register items and compares the output channel against the prediction.
// Depends on sf7_pkg for the item types, register indexes and size constants.
module separable_7tap_image_filter_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  sf7_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  sf7_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sf7_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sf7_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             pixels_in,
  output int                             pixels_out
);
  import sf7_pkg::*;

  localparam int unsigned TAP_WEIGHT [TAPS] = '{2, 15, 62, 98, 62, 15, 2};

  logic [LW_W-1:0] line_width_q;
  logic [FH_W-1:0] frame_height_q;
  pixel_t          row_hist [LINES];
  pixel_t          hline [LINES][MAX_WIDTH];
  int unsigned     col_pos;
  int unsigned     row_pos;
  out_item_t       blur_expected [$];
  int              err_count = 0;
  int              rx_count = 0;
  int              tx_count = 0;

  function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic blur_predict(input in_item_t item);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned slot;
    int unsigned hsum;
    int unsigned vsum;
    pixel_t      hval;
    out_item_t   res;
    w = clamp_range(line_width_q, TAPS, MAX_WIDTH);
    h = clamp_range(frame_height_q, TAPS, MAX_HEIGHT);
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    if (col_pos >= LINES) begin
      x = col_pos - LINES;
      slot = row_pos % LINES;
      hsum = TAP_WEIGHT[LINES] * item.pixel;
      for (int k = 0; k < LINES; k++) hsum += TAP_WEIGHT[k] * row_hist[k];
      hval = pixel_t'(hsum >> 8);
      if (row_pos >= LINES) begin
        vsum = TAP_WEIGHT[LINES] * hval;
        for (int k = 0; k < LINES; k++) begin
          vsum += TAP_WEIGHT[k] * hline[(slot + k) % LINES][x];
        end
        res.filtered_pixel = pixel_t'(vsum >> 8);
        res.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
        blur_expected.insert(blur_expected.size(), res);
      end
      hline[slot][x] = hval;
    end
    for (int k = 0; k < LINES - 1; k++) row_hist[k] = row_hist[k + 1];
    row_hist[LINES - 1] = item.pixel;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic blur_compare(input out_item_t got);
    out_item_t want;
    if (blur_expected.size() == 0) begin
      err_count++;
      $display("%0t: output item with none expected: filtered_pixel %0d frame_last %0d",
               $time, got.filtered_pixel, got.frame_last);
    end else begin
      want = blur_expected.pop_front();
      if (got.filtered_pixel !== want.filtered_pixel) begin
        err_count++;
        $display("%0t: filtered_pixel expected %0d, got %0d",
                 $time, want.filtered_pixel, got.filtered_pixel);
      end
      if (got.frame_last !== want.frame_last) begin
        err_count++;
        $display("%0t: frame_last expected %0d, got %0d",
                 $time, want.frame_last, got.frame_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_width_q = LINE_WIDTH_RESET;
      frame_height_q = FRAME_HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      foreach (row_hist[k]) row_hist[k] = '0;
      foreach (hline[s, a]) hline[s][a] = '0;
      blur_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LINE_WIDTH) begin
          line_width_q = cfg_data[LW_W-1:0];
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          frame_height_q = cfg_data[FH_W-1:0];
        end
      end
      if (out_valid && out_ready) begin
        tx_count++;
        blur_compare(out_item);
      end
      if (in_valid && in_ready) begin
        rx_count++;
        blur_predict(in_item);
      end
    end
    mismatches <= err_count;
    outstanding <= blur_expected.size();
    pixels_in <= rx_count;
    pixels_out <= tx_count;
  end

endmodule

// ----- test/separable_7tap_image_filter_core_test.sv -----
`timescale 1ns / 100ps
// Testbench top for separable_7tap_image_filter_core: drives pixel and register items
// through a directed part and random phases, then reports the verdict.
// Depends on sf7_pkg, the core and separable_7tap_image_filter_checker.
module separable_7tap_image_filter_core_test;
  import sf7_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  in_item_t              in_item = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  out_item_t             out_item;

  int          mismatches;
  int          outstanding;
  int          pixels_in;
  int          pixels_out;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          send_idle_pct = 0;
  int          phase_count = 0;
  int          cycles = 0;
  pixel_t      last_pixel = '0;
  int unsigned frame_pos = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  separable_7tap_image_filter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  separable_7tap_image_filter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .pixels_in   (pixels_in),
    .pixels_out  (pixels_out)
  );

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[separable_7tap_image_filter_core] ERROR");
    $finish;
  end

  // A long hold-off lets the pipeline fill up and back-pressure the pixel input.
  initial begin : receiver
    int hold_count;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(posedge clk);
          hold_count++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_t pick_pixel(input pixel_t prev);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return pixel_t'($urandom_range(0, 255));
    if (r == 6) return '0;
    if (r == 7) return '1;
    return prev;
  endfunction

  task automatic run_phase(input int unsigned lw, input int unsigned fh, input bit fresh,
                           input int unsigned n_items, input int idle, input int stall,
                           input int restart_pct, input bit pressure);
    int unsigned w_eff;
    int unsigned h_eff;
    in_item_t    item;
    drain();
    write_reg(REG_LINE_WIDTH, lw);
    write_reg(REG_FRAME_HEIGHT, fh);
    phase_count++;
    w_eff = (lw < TAPS) ? TAPS : (lw > MAX_WIDTH) ? MAX_WIDTH : lw;
    h_eff = (fh < TAPS) ? TAPS : (fh > MAX_HEIGHT) ? MAX_HEIGHT : fh;
    send_idle_pct = idle;
    stall_pct <= stall;
    if (pressure) hold_requests <= hold_requests + 1;
    if (fresh) frame_pos = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (frame_pos >= w_eff * h_eff) frame_pos = 0;
      item.pixel = pick_pixel(last_pixel);
      last_pixel = item.pixel;
      if (fresh && i == 0) begin
        item.frame_start = 1'b1;
      end else if (frame_pos == 0) begin
        item.frame_start = 1'($urandom_range(0, 1));
      end else begin
        item.frame_start = ($urandom_range(0, 99) < restart_pct);
      end
      if (item.frame_start) frame_pos = 0;
      frame_pos++;
      send_item(item);
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t item;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both registers below range, so the smallest frame applies; the unused index is ignored.
    write_reg(REG_LINE_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_UNUSED, 8191);
    phase_count++;
    for (int i = 0; i < 21; i++) begin
      item.frame_start = (i == 0) || (i == 10);
      item.pixel = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : pixel_t'($urandom_range(0, 255));
      send_item(item);
    end
    in_valid <= 1'b0;

    run_phase(7, 7, 1'b1, 147, 0, 0, 0, 1'b0);
    run_phase(12, 9, 1'b1, 150, 70, 0, 2, 1'b0);
    run_phase(9, 8191, 1'b1, 150, 0, 70, 2, 1'b0);
    run_phase(10, 10, 1'b1, 180, 0, 15, 1, 1'b1);
    // Ends at row 7, column 14, so the next phase shrinks the frame under both counters.
    run_phase(16, 8, 1'b1, 254, 15, 15, 0, 1'b0);
    run_phase(11, 7, 1'b0, 100, 15, 15, 2, 1'b0);
    run_phase(1023, 4096, 1'b1, 60, 0, 0, 0, 1'b0);
    run_phase(8, 7, 1'b1, 90, 15, 15, 3, 1'b0);

    drain();
    $display("Run covered %0d pixel items in %0d register settings, smallest to widest frame,",
             pixels_in, phase_count);
    $display("with %0d filtered pixels checked and %0d mismatches.", pixels_out, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[separable_7tap_image_filter_core] OK");
    end else begin
      $display("[separable_7tap_image_filter_core] ERROR");
    end
    $finish;
  end

endmodule
